// ===== rtl/ple_pkg.sv =====
package ple_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int MODE_W = 3;
  localparam int POS_W  = 7;
  localparam int HDL_W  = 16;
  localparam int STAT_W = 2;
  localparam int TOT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_POS  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_HEAD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REM_TAIL = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REM_POS  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DUMP     = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [HDL_W-1:0]  record_handle;
  } cmd_t;

  typedef struct packed {
    logic [HDL_W-1:0]  out_handle;
    logic [STAT_W-1:0] status;
    logic [TOT_W-1:0]  entry_total;
    logic              last_of_run;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic load;
    logic up;
  } walk_cmd_t;

  typedef struct packed {
    logic vld;
    logic last;
  } walk_fol_t;

endpackage

// ===== rtl/ple_ram.sv =====
module ple_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ple_walk.sv =====
module ple_walk #(
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  ple_pkg::walk_cmd_t  cmd,
  input  logic [AW-1:0]       start_addr,
  input  logic [AW-1:0]       stop_addr,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output ple_pkg::walk_fol_t  fol,
  output logic [AW-1:0]       fol_addr
);

  logic          active;
  logic          up;
  logic [AW-1:0] cur;
  logic [AW-1:0] stop;
  logic          at_stop;
  logic [AW-1:0] step;

  // One incrementer/decrementer and one compare serve every walk.
  assign at_stop = (cur == stop);
  assign step    = up ? cur + AW'(1) : cur - AW'(1);
  assign rd_en   = active;
  assign rd_addr = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      fol    <= '0;
    end else begin
      if (cmd.load) begin
        active <= 1'b1;
      end else if (active && at_stop) begin
        active <= 1'b0;
      end
      fol.vld  <= active;
      fol.last <= active && at_stop;
    end
  end

  // The follow stage lines up with the registered read data of the RAM.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur  <= start_addr;
      stop <= stop_addr;
      up   <= cmd.up;
    end else if (active) begin
      cur <= step;
    end
    fol_addr <= cur;
  end

endmodule

// ===== rtl/positional_list_engine_core.sv =====
// Ordered list of up to CAPACITY handles with positional insert and remove.
// A command word is taken on cmd at a clock edge where start is high and busy
// is low. Each result word appears on result for exactly one cycle with done
// high; the receiver cannot stall, so it must take every word as it comes.
// Path from the accepting edge to the result, with n entries in the list:
//   errors, empty dump, unused mode: result in the next cycle, busy stays low.
//   insert at the tail: the handle is written in S_PUT, which gives the result.
//   insert at position p below n: slots n-1 down to p move back, then S_PUT.
//   remove at position p: slots p to n-1 are read and those above p move down.
//   dump: slots 0 to n-1 are read out one word a cycle, the last marked.
// busy is high from the cycle after acceptance until the final result shows.
// One RAM walk of one entry per cycle is shared by inserts, removes and dumps.
// Reset clears the entry count; the list contents are not cleared and slots
// beyond the count are never read.
module positional_list_engine_core #(
  parameter int CAPACITY    = ple_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = ple_pkg::HANDLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ple_pkg::cmd_t cmd,
  output logic          done,
  output ple_pkg::res_t result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = HANDLE_BITS + ple_pkg::HDL_W;

  ple_pkg::state_t state;
  ple_pkg::state_t state_next;

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [AW-1:0]          pos_q;
  logic [AW-1:0]          pos_next;
  logic [HANDLE_BITS-1:0] hdl_q;
  logic [HANDLE_BITS-1:0] hdl_next;
  logic [HANDLE_BITS-1:0] got_q;
  logic [HANDLE_BITS-1:0] got_next;

  logic                   acc;
  logic                   is_ins;
  logic                   is_rem;
  logic                   is_dump;
  logic                   full;
  logic                   empty;
  logic [ple_pkg::POS_W-1:0] cnt_x;
  logic [ple_pkg::POS_W-1:0] ins_tgt;
  logic [ple_pkg::POS_W-1:0] rem_tgt;
  logic [ple_pkg::POS_W-1:0] tgt;
  logic                   go_put;
  logic                   go_up;
  logic                   go_dn;
  logic                   go_dump;
  logic [ple_pkg::STAT_W-1:0] err_st;
  logic [AW-1:0]          cnt_m1;

  logic [XW-1:0]          in_ext;
  logic [HANDLE_BITS-1:0] hdl_in;
  logic [XW-1:0]          out_ext;

  ple_pkg::walk_cmd_t     wcmd;
  logic [AW-1:0]          w_start;
  logic [AW-1:0]          w_stop;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  ple_pkg::walk_fol_t     fol;
  logic [AW-1:0]          fol_addr;
  logic [HANDLE_BITS-1:0] rdata;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [HANDLE_BITS-1:0] wdata;

  logic                   emit;
  logic [HANDLE_BITS-1:0] emit_h;
  logic [ple_pkg::STAT_W-1:0] emit_st;
  logic [ple_pkg::TOT_W-1:0]  emit_tot;
  logic                   emit_last;
  ple_pkg::res_t          res_next;

  assign busy    = (state != ple_pkg::S_IDLE);
  assign acc     = start && !busy;
  assign cnt_x   = ple_pkg::POS_W'(count);
  assign cnt_m1  = AW'(count - CW'(1));
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign in_ext  = XW'(cmd.record_handle);
  assign hdl_in  = in_ext[HANDLE_BITS-1:0];
  assign out_ext = XW'(emit_h);

  assign res_next = '{out_handle:  out_ext[ple_pkg::HDL_W-1:0],
                      status:      emit_st,
                      entry_total: emit_tot,
                      last_of_run: emit_last};

  // Command decode and the checks that pick the path of a new word.
  always_comb begin
    is_ins  = cmd.mode inside {ple_pkg::MODE_INS_HEAD, ple_pkg::MODE_INS_TAIL,
                               ple_pkg::MODE_INS_POS};
    is_rem  = cmd.mode inside {ple_pkg::MODE_REM_HEAD, ple_pkg::MODE_REM_TAIL,
                               ple_pkg::MODE_REM_POS};
    is_dump = (cmd.mode == ple_pkg::MODE_DUMP);
    ins_tgt = '0;
    rem_tgt = '0;
    case (cmd.mode)
      ple_pkg::MODE_INS_TAIL: ins_tgt = cnt_x;
      ple_pkg::MODE_INS_POS:  ins_tgt = cmd.position;
      ple_pkg::MODE_REM_TAIL: rem_tgt = empty ? '0 : cnt_x - ple_pkg::POS_W'(1);
      ple_pkg::MODE_REM_POS:  rem_tgt = cmd.position;
      default: begin
        ins_tgt = '0;
        rem_tgt = '0;
      end
    endcase
    tgt     = is_ins ? ins_tgt : rem_tgt;
    go_put  = is_ins && !full && (ins_tgt == cnt_x);
    go_up   = is_ins && !full && (ins_tgt < cnt_x);
    go_dn   = is_rem && !empty && (rem_tgt < cnt_x);
    go_dump = is_dump && !empty;
    if (is_ins) begin
      err_st = full ? ple_pkg::ST_FULL : ple_pkg::ST_RANGE;
    end else if (is_rem) begin
      err_st = empty ? ple_pkg::ST_EMPTY : ple_pkg::ST_RANGE;
    end else if (is_dump) begin
      err_st = ple_pkg::ST_EMPTY;
    end else begin
      err_st = ple_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ple_pkg::S_IDLE: begin
        if (acc) begin
          if (go_put) begin
            state_next = ple_pkg::S_PUT;
          end else if (go_up) begin
            state_next = ple_pkg::S_SHIFT_UP;
          end else if (go_dn) begin
            state_next = ple_pkg::S_SHIFT_DN;
          end else if (go_dump) begin
            state_next = ple_pkg::S_DUMP;
          end
        end
      end
      ple_pkg::S_SHIFT_UP: begin
        if (fol.vld && fol.last) begin
          state_next = ple_pkg::S_PUT;
        end
      end
      ple_pkg::S_PUT: begin
        state_next = ple_pkg::S_IDLE;
      end
      ple_pkg::S_SHIFT_DN, ple_pkg::S_DUMP: begin
        if (fol.vld && fol.last) begin
          state_next = ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    pos_next   = pos_q;
    hdl_next   = hdl_q;
    got_next   = got_q;
    wcmd       = '0;
    w_start    = '0;
    w_stop     = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    emit       = 1'b0;
    emit_h     = '0;
    emit_st    = ple_pkg::ST_OK;
    emit_last  = 1'b1;
    case (state)
      ple_pkg::S_IDLE: begin
        if (acc) begin
          pos_next = AW'(tgt);
          hdl_next = hdl_in;
          if (go_up) begin
            // Move entries one place back, from the tail down to the target.
            wcmd    = '{load: 1'b1, up: 1'b0};
            w_start = cnt_m1;
            w_stop  = AW'(tgt);
          end else if (go_dn) begin
            // The first read is the removed word; the rest close the gap.
            wcmd    = '{load: 1'b1, up: 1'b1};
            w_start = AW'(tgt);
            w_stop  = cnt_m1;
          end else if (go_dump) begin
            wcmd    = '{load: 1'b1, up: 1'b1};
            w_start = '0;
            w_stop  = cnt_m1;
          end else if (!go_put) begin
            emit    = 1'b1;
            emit_st = err_st;
          end
        end
      end
      ple_pkg::S_SHIFT_UP: begin
        if (fol.vld) begin
          we    = 1'b1;
          waddr = fol_addr + AW'(1);
          wdata = rdata;
        end
      end
      ple_pkg::S_PUT: begin
        we         = 1'b1;
        waddr      = pos_q;
        wdata      = hdl_q;
        count_next = count + CW'(1);
        emit       = 1'b1;
      end
      ple_pkg::S_SHIFT_DN: begin
        if (fol.vld) begin
          if (fol_addr == pos_q) begin
            got_next = rdata;
          end else begin
            we    = 1'b1;
            waddr = fol_addr - AW'(1);
            wdata = rdata;
          end
          if (fol.last) begin
            count_next = count - CW'(1);
            emit       = 1'b1;
            emit_h     = (fol_addr == pos_q) ? rdata : got_q;
          end
        end
      end
      ple_pkg::S_DUMP: begin
        if (fol.vld) begin
          emit      = 1'b1;
          emit_h    = rdata;
          emit_last = fol.last;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    emit_tot = ple_pkg::TOT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    pos_q <= pos_next;
    hdl_q <= hdl_next;
    got_q <= got_next;
    if (emit) begin
      result <= res_next;
    end
  end

  ple_walk #(
    .AW(AW)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (wcmd),
    .start_addr (w_start),
    .stop_addr  (w_stop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .fol        (fol),
    .fol_addr   (fol_addr)
  );

  ple_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_fol_in_walk: assert property (@(posedge clk) disable iff (rst)
    fol.vld |-> (state == ple_pkg::S_SHIFT_UP || state == ple_pkg::S_SHIFT_DN ||
                 state == ple_pkg::S_DUMP))
    else $error("read data returned outside a walk");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && rd_en) |-> (waddr != rd_addr))
    else $error("write and read hit the same slot");

  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    acc |=> (busy || done))
    else $error("accepted word neither busy nor answered");

endmodule

// ===== bench/tb_positional_list_engine_core.sv =====
`timescale 1ns / 100ps

module tb_positional_list_engine_core;
  import ple_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 380;
  localparam int CYCLE_LIMIT = 400000;
  // Mode 7 has no name in the package; the block treats it as a no-op.
  localparam logic [MODE_W-1:0] MODE_NOP = 3'd7;

  logic clk;
  logic rst;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  res_t result;

  positional_list_engine_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  // Shadow list, updated in acceptance order.
  logic [HDL_W-1:0] slot_model [CAP];
  int live_count = 0;

  cmd_t pending_q[$];
  res_t want_q[$];
  int gen_count = 0;
  int fail_count = 0;
  int cycle_count = 0;
  logic took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    fail_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic push_result(input logic [HDL_W-1:0] hdl, input logic [STAT_W-1:0] st,
                             input logic last);
    res_t r;
    r.out_handle = hdl;
    r.status = st;
    r.entry_total = live_count[TOT_W-1:0];
    r.last_of_run = last;
    want_q.push_back(r);
  endtask

  // Applies one accepted command to the shadow list and queues the words it yields.
  task automatic predict_list_op(input cmd_t c);
    int p;
    int i;
    logic [HDL_W-1:0] got;
    logic [STAT_W-1:0] st;
    got = '0;
    st = ST_OK;
    case (c.mode)
      MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS: begin
        if (c.mode == MODE_INS_HEAD) p = 0;
        else if (c.mode == MODE_INS_TAIL) p = live_count;
        else p = int'(c.position);
        if (live_count >= CAP) begin
          st = ST_FULL;
        end else if (p > live_count) begin
          st = ST_RANGE;
        end else begin
          for (i = live_count; i > p; i--) slot_model[i] = slot_model[i-1];
          slot_model[p] = c.record_handle;
          live_count++;
        end
      end
      MODE_REM_HEAD, MODE_REM_TAIL, MODE_REM_POS: begin
        if (c.mode == MODE_REM_HEAD) p = 0;
        else if (c.mode == MODE_REM_TAIL) p = (live_count == 0) ? 0 : live_count - 1;
        else p = int'(c.position);
        if (live_count == 0) begin
          st = ST_EMPTY;
        end else if (p >= live_count) begin
          st = ST_RANGE;
        end else begin
          got = slot_model[p];
          for (i = p; i + 1 < live_count; i++) slot_model[i] = slot_model[i+1];
          live_count--;
        end
      end
      default: ;
    endcase
    if (c.mode == MODE_DUMP) begin
      if (live_count == 0) begin
        push_result('0, ST_EMPTY, 1'b1);
      end else begin
        for (i = 0; i < live_count; i++) push_result(slot_model[i], ST_OK, i + 1 == live_count);
      end
    end else begin
      push_result(got, st, 1'b1);
    end
  endtask

  task automatic check_word(input res_t got);
    res_t want;
    if (want_q.size() == 0) begin
      note_mismatch($sformatf("word %h arrived with nothing pending", got));
      return;
    end
    want = want_q.pop_front();
    if (got.out_handle !== want.out_handle)
      note_mismatch($sformatf("out_handle %h, want %h", got.out_handle, want.out_handle));
    if (got.status !== want.status)
      note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.entry_total !== want.entry_total)
      note_mismatch($sformatf("entry_total %0d, want %0d", got.entry_total, want.entry_total));
    if (got.last_of_run !== want.last_of_run)
      note_mismatch($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
  endtask

  // Queues a command and tracks the list length it will leave behind.
  task automatic queue_item(input logic [MODE_W-1:0] m, input int pos,
                            input logic [HDL_W-1:0] hdl);
    cmd_t c;
    c.mode = m;
    c.position = pos[POS_W-1:0];
    c.record_handle = hdl;
    pending_q.push_back(c);
    case (m)
      MODE_INS_HEAD, MODE_INS_TAIL: if (gen_count < CAP) gen_count++;
      MODE_INS_POS: if (gen_count < CAP && pos <= gen_count) gen_count++;
      MODE_REM_HEAD, MODE_REM_TAIL: if (gen_count > 0) gen_count--;
      MODE_REM_POS: if (gen_count > 0 && pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (done) check_word(result);
      if (start && !busy) predict_list_op(cmd);
    end
  end

  // Sender: bursts of back-to-back words separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_q.size() != 0) begin
      start <= 1'b1;
      cmd <= pending_q.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[positional_list_engine_core] ERROR");
      $finish;
    end
  end

  initial begin
    int i;
    int r;
    int pos;
    int edge_hits;
    logic grow;
    logic [MODE_W-1:0] m;
    logic [HDL_W-1:0] hdl;

    // Directed part: empty list errors, range errors, ends and middle, no-op mode.
    queue_item(MODE_DUMP, 0, 16'h0000);
    queue_item(MODE_REM_HEAD, 0, 16'h0000);
    queue_item(MODE_REM_TAIL, 0, 16'h0000);
    queue_item(MODE_REM_POS, 0, 16'h0000);
    queue_item(MODE_INS_POS, 1, 16'h1111);
    queue_item(MODE_INS_POS, 0, 16'hFFFF);
    queue_item(MODE_INS_TAIL, 0, 16'h0000);
    queue_item(MODE_INS_HEAD, 0, 16'hA5A5);
    queue_item(MODE_INS_POS, 3, 16'h5A5A);
    queue_item(MODE_INS_POS, 2, 16'h1234);
    queue_item(MODE_INS_POS, 64, 16'h4321);
    queue_item(MODE_REM_POS, 5, 16'h0000);
    queue_item(MODE_REM_POS, 64, 16'hFFFF);
    queue_item(MODE_DUMP, 0, 16'h0000);
    queue_item(MODE_NOP, 64, 16'hBEEF);
    queue_item(MODE_REM_POS, 2, 16'h0000);
    queue_item(MODE_REM_TAIL, 0, 16'h0000);
    queue_item(MODE_REM_HEAD, 0, 16'h0000);
    queue_item(MODE_REM_POS, 0, 16'h0000);
    queue_item(MODE_REM_TAIL, 0, 16'h0000);
    queue_item(MODE_DUMP, 0, 16'h0000);

    // Random part swings the list from empty to full and back, lingering at
    // each end so that full and empty errors come up repeatedly.
    grow = 1'b1;
    edge_hits = 0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) m = MODE_DUMP;
      else if (grow ? (r < 75) : (r >= 75)) m = MODE_INS_HEAD + MODE_W'($urandom_range(0, 2));
      else m = MODE_REM_HEAD + MODE_W'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 85) begin
        if (m == MODE_INS_POS) pos = $urandom_range(0, gen_count);
        else pos = $urandom_range(0, (gen_count == 0) ? 0 : gen_count - 1);
      end else begin
        pos = $urandom_range(0, 64);
      end
      r = $urandom_range(0, 9);
      if (r == 0) hdl = 16'h0000;
      else if (r == 1) hdl = 16'hFFFF;
      else hdl = HDL_W'($urandom_range(0, 65535));
      queue_item(m, pos, hdl);
      if ((grow && gen_count == CAP) || (!grow && gen_count == 0)) edge_hits++;
      if (edge_hits >= 4) begin
        grow = !grow;
        edge_hits = 0;
      end
    end

    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || start || want_q.size() != 0) @(negedge clk);
    repeat (CAP + 8) @(negedge clk);
    if (want_q.size() != 0) note_mismatch($sformatf("%0d words never came", want_q.size()));

    if (fail_count == 0) begin
      $display("[positional_list_engine_core] OK");
    end else begin
      $display("[positional_list_engine_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/ple_walk.sv
rtl/positional_list_engine_core.sv
bench/tb_positional_list_engine_core.sv
